[rtl/assert_macros.svh]
// Assertion macros used by the RTL file that checks its own behavior.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising edge outside reset.
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");

// Condition that must never be seen outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("forbidden condition seen");

`endif

[rtl/hcpd_pkg.sv]
// Package with the types, codes and CRC function of the packet deframer.
package hcpd_pkg;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [14:0] MAX_PAYLOAD_RST = 15'd512;
  localparam logic [14:0] CRC_FIELD_BYTES = 15'd4;
  localparam logic [14:0] TS_FIELD_BYTES = 15'd4;

  // Result kinds carried on out_tuser.
  localparam logic [1:0] KIND_HDR = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_PCRC = 2'd2;

  typedef enum logic [3:0] {
    PH_B0   = 4'd0,
    PH_LEN1 = 4'd1,
    PH_LEN2 = 4'd2,
    PH_SEQ  = 4'd3,
    PH_TS   = 4'd4,
    PH_HCRC = 4'd5,
    PH_PAY  = 4'd6,
    PH_PCRC = 4'd7
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic [1:0]  packet_type;
    logic        truncated;
    logic [4:0]  window;
    logic [7:0]  seqnum;
    logic [14:0] length;
    logic [31:0] timestamp;
    logic        header_crc_ok;
    logic        ignored;
    logic        payload_crc_ok;
    logic        last;
  } result_t;

  // Reflected CRC-32 update by one byte, least significant bit first.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc_in,
                                             input logic [7:0] data);
    logic [31:0] c;
    c = crc_in ^ {24'd0, data};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

[rtl/hcpd_in_reg.sv]
// Input register stage that holds one incoming byte until the parser takes it.
module hcpd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,
  input  logic       take,
  output logic       valid_r,
  output logic [7:0] byte_r
);

  assign in_tready = !valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_tready) begin
      valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      byte_r <= in_tdata;
    end
  end

endmodule

[rtl/hcpd_parser.sv]
// Framing state machine, CRC accumulation and result formation.
module hcpd_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              fire,
  input  logic [7:0]        data_byte,
  input  logic              cfg_valid,
  input  logic [14:0]       cfg_data,
  output logic              res_valid,
  output hcpd_pkg::result_t res
);
  import hcpd_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic [14:0] cnt_r, cnt_nxt, cnt_inc;
  logic [7:0]  byte0_r, byte0_nxt;
  logic [14:0] len_r, len_nxt;
  logic [7:0]  seq_r, seq_nxt;
  logic [31:0] ts_r, ts_nxt;
  logic [31:0] crc_r, crc_nxt;
  logic [31:0] rx_r, rx_nxt;
  logic [14:0] max_payload_r;
  logic [31:0] crc_upd;
  logic        trunc, ign, fin;

  assign cnt_inc = cnt_r + 15'd1;
  assign crc_upd = crc32_byte(crc_r, data_byte);
  assign trunc = byte0_r[5];
  assign ign = ((byte0_r[7:6] != 2'd1) && trunc) || (len_r > max_payload_r);
  assign fin = ign || (len_r == 15'd0);

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    byte0_nxt = byte0_r;
    len_nxt = len_r;
    seq_nxt = seq_r;
    ts_nxt = ts_r;
    crc_nxt = crc_r;
    rx_nxt = rx_r;
    res = '0;
    res_valid = 1'b0;
    if (fire) begin
      unique case (phase_r)
        PH_LEN1: begin
          crc_nxt = crc_upd;
          len_nxt = {8'd0, data_byte[6:0]};
          phase_nxt = data_byte[7] ? PH_LEN2 : PH_SEQ;
        end
        PH_LEN2: begin
          crc_nxt = crc_upd;
          len_nxt = {len_r[6:0], data_byte};
          phase_nxt = PH_SEQ;
        end
        PH_SEQ: begin
          crc_nxt = crc_upd;
          seq_nxt = data_byte;
          cnt_nxt = '0;
          phase_nxt = PH_TS;
        end
        PH_TS: begin
          crc_nxt = crc_upd;
          ts_nxt = {ts_r[23:0], data_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= TS_FIELD_BYTES) begin
            cnt_nxt = '0;
            phase_nxt = PH_HCRC;
          end
        end
        PH_HCRC: begin
          rx_nxt = {rx_r[23:0], data_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CRC_FIELD_BYTES) begin
            res_valid = 1'b1;
            res.kind = KIND_HDR;
            res.packet_type = byte0_r[7:6];
            res.truncated = trunc;
            res.window = byte0_r[4:0];
            res.seqnum = seq_r;
            res.length = len_r;
            res.timestamp = ts_r;
            res.header_crc_ok = (~crc_r == rx_nxt);
            res.ignored = ign;
            res.last = fin;
            crc_nxt = CRC_INIT;
            cnt_nxt = '0;
            phase_nxt = fin ? PH_B0 : PH_PAY;
          end
        end
        PH_PAY: begin
          crc_nxt = crc_upd;
          res_valid = 1'b1;
          res.kind = KIND_PAYLOAD;
          res.payload_byte = data_byte;
          cnt_nxt = cnt_inc;
          if (cnt_inc >= len_r) begin
            cnt_nxt = '0;
            phase_nxt = PH_PCRC;
          end
        end
        PH_PCRC: begin
          rx_nxt = {rx_r[23:0], data_byte};
          cnt_nxt = cnt_inc;
          if (cnt_inc >= CRC_FIELD_BYTES) begin
            res_valid = 1'b1;
            res.kind = KIND_PCRC;
            res.payload_crc_ok = (~crc_r == rx_nxt);
            res.last = 1'b1;
            cnt_nxt = '0;
            phase_nxt = PH_B0;
          end
        end
        default: begin
          // First header byte; unused phase codes land here as well.
          byte0_nxt = data_byte;
          len_nxt = '0;
          crc_nxt = crc32_byte(CRC_INIT, data_byte);
          cnt_nxt = '0;
          phase_nxt = PH_LEN1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_B0;
      cnt_r <= '0;
      crc_r <= CRC_INIT;
      max_payload_r <= MAX_PAYLOAD_RST;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      crc_r <= crc_nxt;
      if (cfg_valid) begin
        max_payload_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    byte0_r <= byte0_nxt;
    len_r <= len_nxt;
    seq_r <= seq_nxt;
    ts_r <= ts_nxt;
    rx_r <= rx_nxt;
  end

endmodule

[rtl/hcpd_out_reg.sv]
// Result register that holds one finished item until the sink takes it.
module hcpd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load,
  input  hcpd_pkg::result_t res_in,
  input  logic              out_tready,
  output logic              can_load,
  output logic              valid_r,
  output hcpd_pkg::result_t res_r
);
  import hcpd_pkg::*;

  assign can_load = !valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (can_load) begin
      valid_r <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (can_load && load) begin
      res_r <= res_in;
    end
  end

endmodule

[rtl/header_crc_packet_deframer.sv]
// Top level of the header and payload CRC-32 packet deframer.
// One packet byte is taken per cycle when neither side stalls, and every byte is processed
// combinationally between the input register and the result register, so each byte is held in
// the input register and its result in the result register before the result can be taken; the
// byte-wide CRC update sets the cycle time. A full result register that is not taken also holds
// back header bytes that give no item. A header item is given on the last header CRC byte, each
// payload byte gives one item, and the last payload CRC byte gives a status item; packets
// flagged ignored or with no payload end at the header item.
// The limit register cfg_data is taken at any cfg_valid and should only change between packets.
`include "assert_macros.svh"

module header_crc_packet_deframer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  // [7:0] payload_byte, [9:8] packet_type, [10] truncated, [15:11] window,
  // [23:16] seqnum, [38:24] length, [70:39] timestamp, [71] header_crc_ok,
  // [72] ignored, [73] payload_crc_ok, [79:74] zero
  output logic [79:0] out_tdata,
  output logic [1:0]  out_tuser,  // [1:0] kind
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data    // max_payload
);
  import hcpd_pkg::*;

  logic    in_valid_r;
  logic [7:0] in_byte_r;
  logic    fire;
  logic    can_load;
  logic    res_valid;
  result_t res;
  result_t res_r;

  assign cfg_ready = 1'b1;
  assign fire = in_valid_r && can_load;

  hcpd_in_reg u_in_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .take      (fire),
    .valid_r   (in_valid_r),
    .byte_r    (in_byte_r)
  );

  hcpd_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .data_byte (in_byte_r),
    .cfg_valid (cfg_valid),
    .cfg_data  (cfg_data),
    .res_valid (res_valid),
    .res       (res)
  );

  hcpd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (res_valid && fire),
    .res_in     (res),
    .out_tready (out_tready),
    .can_load   (can_load),
    .valid_r    (out_tvalid),
    .res_r      (res_r)
  );

  assign out_tdata = {6'd0, res_r.payload_crc_ok, res_r.ignored, res_r.header_crc_ok,
                      res_r.timestamp, res_r.length, res_r.seqnum, res_r.window,
                      res_r.truncated, res_r.packet_type, res_r.payload_byte};
  assign out_tuser = res_r.kind;
  assign out_tlast = res_r.last;

  `ASSERT_ALWAYS(a_payload_not_last, clk, rst_n,
                 (out_tvalid && out_tuser == KIND_PAYLOAD) |-> !out_tlast)
  `ASSERT_ALWAYS(a_pcrc_is_last, clk, rst_n,
                 (out_tvalid && out_tuser == KIND_PCRC) |-> out_tlast)
  `ASSERT_ALWAYS(a_byte_only_payload, clk, rst_n,
                 (out_tvalid && out_tuser != KIND_PAYLOAD) |-> (out_tdata[7:0] == 8'd0))
  `ASSERT_ALWAYS(a_ready_when_drained, clk, rst_n, !out_tvalid |-> in_tready)

endmodule
